FILE: src/u8u16_pkg.sv
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared constants and types of the UTF-8 to UTF-16 stream decoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

  localparam int ByteW   = 8;
  localparam int UnitW   = 16;
  localparam int PendW   = 2;
  localparam int PartW   = 10;
  localparam int PayW    = 6;

  localparam logic [ByteW-1:0] ClassMask  = 8'hC0;
  localparam logic [ByteW-1:0] ContTag    = 8'h80;
  localparam logic [ByteW-1:0] Lead3Min   = 8'hE0;
  localparam logic [ByteW-1:0] LeadBadMin = 8'hF8;
  localparam logic [ByteW-1:0] Lead2Mask  = 8'h1F;
  localparam logic [ByteW-1:0] PayMask    = 8'h3F;
  localparam logic [ByteW-1:0] Lead3Mask  = 8'h0F;

  localparam logic [PendW-1:0] PendNone = 2'd0;
  localparam logic [PendW-1:0] PendOne  = 2'd1;
  localparam logic [PendW-1:0] PendTwo  = 2'd2;

  typedef struct packed {
    logic [UnitW-1:0] code_unit;
    logic             unit_valid;
    logic             end_of_string;
    logic             string_error;
  } result_t;

endpackage

FILE: src/utf8_to_utf16_stream_decoder.sv
// ----------------------------------------------------------------------------
// utf8_to_utf16_stream_decoder
// Decodes a UTF-8 byte stream into 16-bit code units, with end-of-string and
// error status on the result of the final byte.
// ----------------------------------------------------------------------------
// a result is registered and appears on the output in the cycle after its byte transfer
// throughput: one byte per cycle while the input is not stalled by a held output
// the output register is freed in the same cycle it is taken
// reset clears the pending count, accumulator, error flag and output valid
module utf8_to_utf16_stream_decoder
  import u8u16_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [ByteW-1:0] byte_in_i,
  input  logic             last_byte_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [UnitW-1:0] code_unit_o,
  output logic             unit_valid_o,
  output logic             end_of_string_o,
  output logic             string_error_o
);

  logic [PendW-1:0] bytes_pending_q, bytes_pending_d;
  logic [PartW-1:0] partial_value_q, partial_value_d;
  logic             error_seen_q, error_seen_d;
  logic             out_valid_q, out_valid_d;
  result_t          res_q, res_d;

  logic             in_xfer;
  logic             have_unit;
  logic [UnitW-1:0] unit;
  logic [UnitW-1:0] acc;
  logic             emit;
  logic             str_err;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign acc        = {partial_value_q, byte_in_i[PayW-1:0]};

  always_comb begin
    bytes_pending_d = bytes_pending_q;
    partial_value_d = partial_value_q;
    error_seen_d    = error_seen_q;
    have_unit       = 1'b0;
    unit            = '0;
    if (!error_seen_q) begin
      if (bytes_pending_q != PendNone) begin
        bytes_pending_d = bytes_pending_q - PendOne;
        if (bytes_pending_q == PendOne) begin
          unit            = acc;
          have_unit       = 1'b1;
          partial_value_d = '0;
        end else begin
          partial_value_d = acc[PartW-1:0];
        end
      end else if ((byte_in_i & ClassMask) == ContTag) begin
        error_seen_d = 1'b1;
      end else if (byte_in_i < ContTag) begin
        unit      = {{(UnitW-ByteW){1'b0}}, byte_in_i};
        have_unit = 1'b1;
      end else if (byte_in_i < Lead3Min) begin
        partial_value_d = {{(PartW-ByteW){1'b0}}, byte_in_i & Lead2Mask};
        bytes_pending_d = PendOne;
      end else if (byte_in_i < LeadBadMin) begin
        partial_value_d = {{(PartW-ByteW){1'b0}}, byte_in_i & Lead3Mask};
        bytes_pending_d = PendTwo;
      end else begin
        error_seen_d = 1'b1;
      end
    end

    str_err = error_seen_d || (bytes_pending_d != PendNone);
    emit    = last_byte_i || have_unit;

    res_d.end_of_string = last_byte_i;
    res_d.string_error  = last_byte_i && str_err;
    res_d.unit_valid    = have_unit && !(last_byte_i && str_err);
    res_d.code_unit     = res_d.unit_valid ? unit : '0;

    if (last_byte_i) begin
      bytes_pending_d = PendNone;
      partial_value_d = '0;
      error_seen_d    = 1'b0;
    end

    out_valid_d = out_valid_q && out_stall_i;
    if (in_xfer && emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_pending_q <= PendNone;
      partial_value_q <= '0;
      error_seen_q    <= 1'b0;
      out_valid_q     <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_xfer) begin
        bytes_pending_q <= bytes_pending_d;
        partial_value_q <= partial_value_d;
        error_seen_q    <= error_seen_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && emit) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign code_unit_o     = res_q.code_unit;
  assign unit_valid_o    = res_q.unit_valid;
  assign end_of_string_o = res_q.end_of_string;
  assign string_error_o  = res_q.string_error;

`ifndef NO_ASSERTIONS
  a_pend_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bytes_pending_q != 2'd3)
    else $error("pending count out of range");

  a_err_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    error_seen_q |-> bytes_pending_q == PendNone)
    else $error("error flag set with followers pending");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && last_byte_i |=> bytes_pending_q == PendNone && !error_seen_q)
    else $error("state not cleared after final byte");

  a_result_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_q.unit_valid || res_q.end_of_string) &&
                    !(res_q.string_error && res_q.unit_valid))
    else $error("malformed result");

  a_result_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && last_byte_i |=> out_valid_q && res_q.end_of_string)
    else $error("final byte gave no result");
`endif

endmodule

FILE: tb/utf8_to_utf16_stream_decoder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf8_to_utf16_stream_decoder_tb
// Self-checking bench for the UTF-8 to UTF-16 stream decoder. A queue of
// bytes, directed corner strings first and then random strings (mostly well
// formed, some with stray bytes or cut short), feeds a clocked driver. A
// clocked monitor decodes every accepted byte in its own model of the block
// and checks each output transfer against the oldest expected result.
// Both sides idle at random, and once the receiver holds off for a long
// stretch so that the decoder backs up and stalls its input.
// ----------------------------------------------------------------------------
module utf8_to_utf16_stream_decoder_tb
  import u8u16_pkg::*;
();

  typedef struct {
    logic [ByteW-1:0] data;
    logic             last;
  } utf8_byte_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [ByteW-1:0] byte_in = '0;
  logic             last_byte = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [UnitW-1:0] code_unit;
  logic             unit_valid;
  logic             end_of_string;
  logic             string_error;

  utf8_byte_t pending_bytes[$];
  result_t    expected_units[$];

  logic [PendW-1:0] dec_pending = PendNone;
  logic [PartW-1:0] dec_partial = '0;
  logic             dec_error   = 1'b0;

  logic byte_taken = 1'b0;
  int   total_bytes = 0;
  int   total_strings = 0;
  int   bytes_taken = 0;
  int   units_seen = 0;
  int   clean_ends = 0;
  int   error_ends = 0;
  int   failures = 0;
  int   hold_left = 0;
  bit   hold_done = 1'b0;

  utf8_to_utf16_stream_decoder dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .byte_in_i      (byte_in),
    .last_byte_i    (last_byte),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .code_unit_o    (code_unit),
    .unit_valid_o   (unit_valid),
    .end_of_string_o(end_of_string),
    .string_error_o (string_error)
  );

  always #5 clk_i = ~clk_i;

  // first third: sender idles less, then receiver idles less, then no idling
  function automatic int idle_pct(input bit receiver);
    int phase;
    phase = (total_bytes == 0) ? 2 : bytes_taken * 3 / total_bytes;
    if (phase == 0) begin
      return receiver ? 55 : 31;
    end else if (phase == 1) begin
      return receiver ? 31 : 55;
    end
    return 0;
  endfunction

  function automatic void decode_byte(input logic [ByteW-1:0] b, input logic last,
                                      output bit has_result, output result_t res);
    logic [UnitW-1:0] acc;
    logic [UnitW-1:0] unit;
    bit               have_unit;
    have_unit  = 1'b0;
    unit       = '0;
    res        = '0;
    has_result = 1'b0;
    if (!dec_error) begin
      if (dec_pending != PendNone) begin
        acc         = {dec_partial, b[PayW-1:0]};
        dec_pending = dec_pending - 1'b1;
        if (dec_pending == PendNone) begin
          unit        = acc;
          have_unit   = 1'b1;
          dec_partial = '0;
        end else begin
          dec_partial = acc[PartW-1:0];
        end
      end else if ((b & ClassMask) == ContTag) begin
        dec_error = 1'b1;
      end else if (b < ContTag) begin
        unit      = UnitW'(b);
        have_unit = 1'b1;
      end else if (b < Lead3Min) begin
        dec_partial = PartW'(b & Lead2Mask);
        dec_pending = PendOne;
      end else if (b < LeadBadMin) begin
        dec_partial = PartW'(b & Lead3Mask);
        dec_pending = PendTwo;
      end else begin
        dec_error = 1'b1;
      end
    end
    if (last) begin
      has_result        = 1'b1;
      res.end_of_string = 1'b1;
      if (dec_error || dec_pending != PendNone) begin
        res.string_error = 1'b1;
      end else if (have_unit) begin
        res.code_unit  = unit;
        res.unit_valid = 1'b1;
      end
      dec_pending = PendNone;
      dec_partial = '0;
      dec_error   = 1'b0;
    end else if (have_unit) begin
      has_result     = 1'b1;
      res.code_unit  = unit;
      res.unit_valid = 1'b1;
    end
  endfunction

  task automatic report_failure(input string what, input result_t exp, input result_t got);
    failures++;
    if (failures <= 10) begin
      $display("%t %s: expected unit %h valid %b eos %b err %b, got unit %h valid %b eos %b err %b",
               $time, what, exp.code_unit, exp.unit_valid, exp.end_of_string,
               exp.string_error, got.code_unit, got.unit_valid, got.end_of_string,
               got.string_error);
    end
  endtask

  task automatic add_byte(input logic [ByteW-1:0] b, input logic last);
    utf8_byte_t item;
    item.data = b;
    item.last = last;
    pending_bytes.push_back(item);
    total_bytes++;
    if (last) begin
      total_strings++;
    end
  endtask

  // driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (!in_valid || byte_taken) begin
      if (pending_bytes.size() != 0 &&
          (hold_left != 0 || $urandom_range(99) >= idle_pct(1'b0))) begin
        byte_in   <= pending_bytes[0].data;
        last_byte <= pending_bytes[0].last;
        pending_bytes.delete(0);
        in_valid  <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall, with one long hold-off late in the run
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else if (!hold_done && bytes_taken >= total_bytes * 5 / 6) begin
      hold_done <= 1'b1;
      hold_left <= 40;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < idle_pct(1'b1));
    end
  end

  // monitor
  always @(posedge clk_i) begin
    result_t got;
    result_t exp;
    bit      has_result;
    if (!rst_ni) begin
      byte_taken <= 1'b0;
    end else begin
      byte_taken <= in_valid && !in_stall;
      if (out_valid && !out_stall) begin
        got.code_unit     = code_unit;
        got.unit_valid    = unit_valid;
        got.end_of_string = end_of_string;
        got.string_error  = string_error;
        if (expected_units.size() == 0) begin
          report_failure("unexpected transfer", '0, got);
        end else begin
          exp = expected_units.pop_front();
          if (got.code_unit !== exp.code_unit || got.unit_valid !== exp.unit_valid ||
              got.end_of_string !== exp.end_of_string ||
              got.string_error !== exp.string_error) begin
            report_failure("mismatch", exp, got);
          end
          if (exp.unit_valid) begin
            units_seen++;
          end
          if (exp.end_of_string && exp.string_error) begin
            error_ends++;
          end else if (exp.end_of_string) begin
            clean_ends++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        decode_byte(byte_in, last_byte, has_result, exp);
        if (has_result) begin
          expected_units.push_back(exp);
        end
        bytes_taken++;
      end
    end
  end

  initial begin
    int               n_chars;
    int               kind;
    int               directed;
    logic [ByteW-1:0] str[$];

    // ascii at both ends: 0x00 as a string alone, 0x7f opening the next string
    add_byte(8'h00, 1'b1);
    add_byte(8'h7f, 1'b0);
    // two-byte forms with lowest and highest leads, the string ending on the byte completing a character
    add_byte(8'hc0, 1'b0); add_byte(8'h80, 1'b1);
    add_byte(8'hdf, 1'b0); add_byte(8'hbf, 1'b0);
    // three-byte forms, unchecked follower with high bits set
    add_byte(8'he0, 1'b0); add_byte(8'h80, 1'b0); add_byte(8'h80, 1'b0);
    add_byte(8'hf7, 1'b0); add_byte(8'hff, 1'b0); add_byte(8'h3f, 1'b1);
    // stray continuation then bytes that are dropped
    add_byte(8'h80, 1'b0); add_byte(8'h41, 1'b0); add_byte(8'hc2, 1'b1);
    // bad leads
    add_byte(8'hf8, 1'b1);
    add_byte(8'hff, 1'b0); add_byte(8'h20, 1'b1);
    // cut short by end of string
    add_byte(8'hc2, 1'b1);
    add_byte(8'he1, 1'b0); add_byte(8'h80, 1'b1);
    // follower with ascii top bits
    add_byte(8'hc3, 1'b0); add_byte(8'h41, 1'b1);
    directed = total_bytes;

    while (total_bytes < directed + 400) begin
      n_chars = $urandom_range(1, 8);
      kind    = $urandom_range(99);
      str.delete();
      for (int i = 0; i < n_chars; i++) begin
        case ($urandom_range(2))
          0: str.push_back(ByteW'($urandom_range(8'h7f)));
          1: str.push_back(ByteW'($urandom_range(8'hc0, 8'hdf)));
          default: str.push_back(ByteW'($urandom_range(8'he0, 8'hf7)));
        endcase
        for (int f = (str[$] >= Lead3Min) ? 2 : (str[$] >= 8'hc0) ? 1 : 0; f > 0; f--) begin
          str.push_back(($urandom_range(9) == 0) ? ByteW'($urandom_range(255)) :
                                                   ByteW'($urandom_range(8'h80, 8'hbf)));
        end
      end
      if (kind < 10) begin
        str.insert($urandom_range(str.size()), ByteW'($urandom_range(255)));
      end else if (kind < 18 && str.size() > 1) begin
        void'(str.pop_back());
      end
      foreach (str[i]) begin
        add_byte(str[i], i == str.size() - 1);
      end
    end

    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    while (bytes_taken < total_bytes) @(negedge clk_i);
    while (expected_units.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);

    $display("sent %0d bytes in %0d strings (directed corners, random strings, stray bytes)",
             total_bytes, total_strings);
    $display("checked %0d code units, %0d clean and %0d failed string ends, %0d failures",
             units_seen, clean_ends, error_ends, failures);
    if (failures == 0) begin
      $display("PASS utf8_to_utf16_stream_decoder");
    end else begin
      $display("FAIL utf8_to_utf16_stream_decoder");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout with %0d results still expected", expected_units.size());
    $display("FAIL utf8_to_utf16_stream_decoder");
    $finish;
  end

endmodule

FILE: filelist.f
src/u8u16_pkg.sv
src/utf8_to_utf16_stream_decoder.sv
tb/utf8_to_utf16_stream_decoder_tb.sv
